### rtl/assert_macros.svh
// Assertion macros shared by the linked deque RTL.
// Each macro expects a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define LDQ_ASSERT(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);

// Same-cycle implication.
`define LDQ_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define LDQ_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/ldq_pkg.sv
// Constants and request codes for the linked deque manager.
// No dependencies; imported by the core and its testbench.
package ldq_pkg;

    localparam int NODES    = 256;
    localparam int ADDR_W   = $clog2(NODES);
    localparam int LINK_W   = $clog2(NODES + 1);
    localparam int COUNT_W  = 9;
    localparam int KIND_W   = 3;
    localparam int NODE_W   = 8;
    localparam int CHOICE_W = 2;

    localparam logic [LINK_W-1:0] LINK_NONE = LINK_W'(NODES);

    localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd0;
    localparam logic [KIND_W-1:0] KIND_PUSH_REAR  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_POP_REAR   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_UNLINK     = 3'd4;

    localparam logic [CHOICE_W-1:0] CHOICE_PREV = 2'd1;
    localparam logic [CHOICE_W-1:0] CHOICE_NEXT = 2'd2;

endpackage

### rtl/linked_deque_manager_core.sv
// Linked deque manager core: push, pop and unlink on a linked deque; uses ldq_pkg and ldq_ram.
// An accepted item passes through STEP1 and STEP2, and its result is registered and strobed
// on o_valid after STEP2. A new item is taken in idle or as the current one finishes, since the
// read-then-write pass through the link RAMs must complete; an unlink of a node with no next
// (previous) link that is not itself the tail (head) goes through STEP1 and STEP2 twice. The receiver cannot stall.
// Reset (synchronous, active low) empties the deque; the link RAMs are not cleared.
`include "assert_macros.svh"

module linked_deque_manager_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [ldq_pkg::KIND_W-1:0]   i_kind,
    input  logic [ldq_pkg::NODE_W-1:0]   i_node,
    input  logic [ldq_pkg::CHOICE_W-1:0] i_return_choice,
    output logic                         o_valid,
    output logic                         o_status,
    output logic                         o_neighbor_valid,
    output logic [ldq_pkg::NODE_W-1:0]   o_neighbor,
    output logic [ldq_pkg::COUNT_W-1:0]  o_count_after
);
    import ldq_pkg::*;

    // Sequencer states. STEP1 issues the link reads (or the first push writes),
    // STEP2 sees the read data, writes neighbor links back and finishes the item or sends an unlink back to STEP1.
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_STEP1 = 2'd1;
    localparam logic [1:0] ST_STEP2 = 2'd2;

    logic [1:0]          r_state, n_state;
    logic [KIND_W-1:0]   r_kind, n_kind;
    logic [NODE_W-1:0]   r_node, n_node;
    logic [CHOICE_W-1:0] r_choice, n_choice;
    // Set when an unlink has been turned into a pop of the matching end; the
    // unlinked node's former neighbors are then held in r_pv and r_nx.
    logic                r_unl, n_unl;
    logic [LINK_W-1:0]   r_pv, n_pv;
    logic [LINK_W-1:0]   r_nx, n_nx;
    // The read address of the previous/next RAM was "none": its data reads as none.
    logic                r_pnone, n_pnone;
    logic                r_nnone, n_nnone;
    logic [LINK_W-1:0]   r_head, n_head;
    logic [LINK_W-1:0]   r_tail, n_tail;
    logic [COUNT_W-1:0]  r_count, n_count;

    logic                r_valid;
    logic                r_status;
    logic                r_nvalid;
    logic [NODE_W-1:0]   r_nb;

    // Link RAM ports.
    logic                prev_we, next_we;
    logic [ADDR_W-1:0]   prev_waddr, next_waddr, prev_raddr, next_raddr;
    logic [LINK_W-1:0]   prev_wdata, next_wdata, prev_rdata, next_rdata;

    logic                accept;
    logic                finish;
    logic                fin_status;
    logic                fin_nvalid;
    logic [NODE_W-1:0]   fin_nb;
    logic                do_tf, do_tr;
    logic [LINK_W-1:0]   node_link;
    logic [LINK_W-1:0]   rd_prev_v, rd_next_v;
    logic [LINK_W-1:0]   sel_pv, sel_nx;
    logic                cnt_zero, cnt_one;
    logic                nb_en;

    ldq_ram #(
        .WIDTH (LINK_W),
        .DEPTH (NODES)
    ) u_prev_ram (
        .i_clk   (i_clk),
        .i_we    (prev_we),
        .i_waddr (prev_waddr),
        .i_wdata (prev_wdata),
        .i_raddr (prev_raddr),
        .o_rdata (prev_rdata)
    );

    ldq_ram #(
        .WIDTH (LINK_W),
        .DEPTH (NODES)
    ) u_next_ram (
        .i_clk   (i_clk),
        .i_we    (next_we),
        .i_waddr (next_waddr),
        .i_wdata (next_wdata),
        .i_raddr (next_raddr),
        .o_rdata (next_rdata)
    );

    assign node_link = LINK_W'(r_node);
    assign cnt_zero  = (r_count == '0);
    assign cnt_one   = (r_count == COUNT_W'(1));
    // A read of the "none" handle yields none.
    assign rd_prev_v = r_pnone ? LINK_NONE : prev_rdata;
    assign rd_next_v = r_nnone ? LINK_NONE : next_rdata;
    // For a rerouted unlink the neighbors come from the saved links.
    assign sel_pv    = r_unl ? r_pv : rd_prev_v;
    assign sel_nx    = r_unl ? r_nx : rd_next_v;

    // Read addresses are driven in STEP1; the data is used in STEP2. A pop of the
    // front reads the head's next link, a pop of the rear the tail's previous link,
    // and an unlink reads both links of the named node.
    assign prev_raddr = (r_kind == KIND_POP_REAR) ? r_tail[ADDR_W-1:0] : r_node;
    assign next_raddr = (r_kind == KIND_POP_FRONT) ? r_head[ADDR_W-1:0] : r_node;

    always_comb begin
        n_state    = r_state;
        n_kind     = r_kind;
        n_node     = r_node;
        n_choice   = r_choice;
        n_unl      = r_unl;
        n_pv       = r_pv;
        n_nx       = r_nx;
        n_pnone    = r_pnone;
        n_nnone    = r_nnone;
        n_head     = r_head;
        n_tail     = r_tail;
        n_count    = r_count;
        prev_we    = 1'b0;
        prev_waddr = r_node;
        prev_wdata = LINK_NONE;
        next_we    = 1'b0;
        next_waddr = r_node;
        next_wdata = LINK_NONE;
        finish     = 1'b0;
        fin_status = 1'b0;
        do_tf      = 1'b0;
        do_tr      = 1'b0;
        nb_en      = 1'b0;

        unique case (r_state)
            ST_STEP1: begin
                n_pnone = (r_kind == KIND_POP_REAR) && (r_tail == LINK_NONE);
                n_nnone = (r_kind == KIND_POP_FRONT) && (r_head == LINK_NONE);
                // A pushed node gets both of its links written here.
                if (r_kind == KIND_PUSH_FRONT || r_kind == KIND_PUSH_REAR) begin
                    prev_we    = 1'b1;
                    prev_wdata = (r_kind == KIND_PUSH_FRONT || cnt_zero) ? LINK_NONE : r_tail;
                    next_we    = 1'b1;
                    next_wdata = (r_kind == KIND_PUSH_REAR || cnt_zero) ? LINK_NONE : r_head;
                end
                n_state = ST_STEP2;
            end
            ST_STEP2: begin
                finish = 1'b1;
                case (r_kind) inside
                    KIND_PUSH_FRONT, KIND_PUSH_REAR: begin
                        if (cnt_zero) begin
                            n_head = node_link;
                            n_tail = node_link;
                        end else if (r_kind == KIND_PUSH_FRONT) begin
                            prev_we    = (r_head != LINK_NONE);
                            prev_waddr = r_head[ADDR_W-1:0];
                            prev_wdata = node_link;
                            n_head     = node_link;
                        end else begin
                            next_we    = (r_tail != LINK_NONE);
                            next_waddr = r_tail[ADDR_W-1:0];
                            next_wdata = node_link;
                            n_tail     = node_link;
                        end
                        // The count saturates when the deque is full.
                        if (r_count < COUNT_W'(NODES)) begin
                            n_count = r_count + COUNT_W'(1);
                        end
                    end
                    KIND_POP_FRONT, KIND_POP_REAR: begin
                        nb_en = r_unl;
                        if (cnt_zero) begin
                            fin_status = 1'b1;
                        end else if (r_kind == KIND_POP_FRONT) begin
                            do_tf = 1'b1;
                        end else begin
                            do_tr = 1'b1;
                        end
                    end
                    KIND_UNLINK: begin
                        n_pv = prev_rdata;
                        n_nx = next_rdata;
                        if (cnt_zero) begin
                            fin_status = 1'b1;
                        end else begin
                            nb_en = 1'b1;
                            if (next_rdata == LINK_NONE) begin
                                // No next link: the rear is taken. When the tail is
                                // some other node its previous link must be read first.
                                if (cnt_one || r_tail == node_link) begin
                                    do_tr = 1'b1;
                                end else begin
                                    finish  = 1'b0;
                                    n_kind  = KIND_POP_REAR;
                                    n_unl   = 1'b1;
                                    n_state = ST_STEP1;
                                end
                            end else if (prev_rdata == LINK_NONE) begin
                                if (cnt_one || r_head == node_link) begin
                                    do_tf = 1'b1;
                                end else begin
                                    finish  = 1'b0;
                                    n_kind  = KIND_POP_FRONT;
                                    n_unl   = 1'b1;
                                    n_state = ST_STEP1;
                                end
                            end else begin
                                // Splice the node out between its two neighbors.
                                next_we    = 1'b1;
                                next_waddr = prev_rdata[ADDR_W-1:0];
                                next_wdata = next_rdata;
                                prev_we    = 1'b1;
                                prev_waddr = next_rdata[ADDR_W-1:0];
                                prev_wdata = prev_rdata;
                                n_count    = r_count - COUNT_W'(1);
                            end
                        end
                    end
                    default: begin
                    end
                endcase

                // Taking the front: the head's successor loses its previous link.
                if (do_tf) begin
                    if (cnt_one) begin
                        n_head = LINK_NONE;
                        n_tail = LINK_NONE;
                    end else begin
                        prev_we    = (rd_next_v != LINK_NONE);
                        prev_waddr = rd_next_v[ADDR_W-1:0];
                        prev_wdata = LINK_NONE;
                        n_head     = rd_next_v;
                    end
                    n_count = r_count - COUNT_W'(1);
                end
                // Taking the rear: the tail's predecessor loses its next link.
                if (do_tr) begin
                    if (cnt_one) begin
                        n_head = LINK_NONE;
                        n_tail = LINK_NONE;
                    end else begin
                        next_we    = (rd_prev_v != LINK_NONE);
                        next_waddr = rd_prev_v[ADDR_W-1:0];
                        next_wdata = LINK_NONE;
                        n_tail     = rd_prev_v;
                    end
                    n_count = r_count - COUNT_W'(1);
                end
                if (finish) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
            end
        endcase

        // A new item is taken in idle or in the cycle the current one finishes;
        // every link write of the finishing item lands before the new reads.
        if (accept) begin
            n_state  = ST_STEP1;
            n_kind   = i_kind;
            n_node   = i_node;
            n_choice = i_return_choice;
            n_unl    = 1'b0;
        end
    end

    assign busy   = (r_state != ST_IDLE) && !finish;
    assign accept = start && !busy;

    // Neighbor handed back by an unlink.
    always_comb begin
        fin_nvalid = 1'b0;
        fin_nb     = '0;
        if (nb_en) begin
            if (r_choice == CHOICE_PREV && sel_pv != LINK_NONE) begin
                fin_nvalid = 1'b1;
                fin_nb     = sel_pv[NODE_W-1:0];
            end else if (r_choice == CHOICE_NEXT && sel_nx != LINK_NONE) begin
                fin_nvalid = 1'b1;
                fin_nb     = sel_nx[NODE_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_unl   <= 1'b0;
            r_head  <= LINK_NONE;
            r_tail  <= LINK_NONE;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_unl   <= n_unl;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
            r_valid <= finish;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind   <= n_kind;
        r_node   <= n_node;
        r_choice <= n_choice;
        r_pv     <= n_pv;
        r_nx     <= n_nx;
        r_pnone  <= n_pnone;
        r_nnone  <= n_nnone;
        if (finish) begin
            r_status <= fin_status;
            r_nvalid <= fin_nvalid;
            r_nb     <= fin_nb;
        end
    end

    // The count register only changes at the finishing edge, so it stays valid
    // for the whole strobe cycle.
    assign o_valid          = r_valid;
    assign o_status         = r_status;
    assign o_neighbor_valid = r_nvalid;
    assign o_neighbor       = r_nb;
    assign o_count_after    = r_count;

    `LDQ_ASSERT(a_count_range, r_count <= COUNT_W'(NODES), "member count above capacity")
    `LDQ_ASSERT_NXT(a_step1_next, r_state == ST_STEP1, r_state == ST_STEP2, "step1 stalled")
    `LDQ_ASSERT_NXT(a_accept_step, start && !busy, r_state == ST_STEP1, "item did not start")
    `LDQ_ASSERT_NXT(a_strobe_single, o_valid, !o_valid, "result strobe held two cycles")
    `LDQ_ASSERT_IMP(a_empty_flag, o_valid && o_status, !o_neighbor_valid, "bad empty flag")

endmodule

### rtl/ldq_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
module ldq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### verif/linked_deque_manager_core_tb.sv
// Self-checking testbench for the linked deque manager core.
// Depends on ldq_pkg and linked_deque_manager_core; it mirrors the deque in its own link
// tables and checks every result the core strobes against that mirror.
module linked_deque_manager_core_tb;

    import ldq_pkg::*;

    // Request codes and status values that the package leaves unnamed.
    localparam logic [KIND_W-1:0]   KIND_RESERVED_LO = 3'd5;
    localparam logic [KIND_W-1:0]   KIND_RESERVED_HI = 3'd7;
    localparam logic [CHOICE_W-1:0] CHOICE_NONE      = 2'd0;
    localparam logic [CHOICE_W-1:0] CHOICE_RESERVED  = 2'd3;
    localparam logic                STATUS_DONE      = 1'b0;
    localparam logic                STATUS_EMPTY     = 1'b1;

    // One result of the core, as the mirror predicts it.
    typedef struct packed {
        logic                status;
        logic                neighbor_valid;
        logic [NODE_W-1:0]   neighbor;
        logic [COUNT_W-1:0]  count_after;
    } t_deque_outcome;

    logic                i_clk;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    logic [KIND_W-1:0]   i_kind;
    logic [NODE_W-1:0]   i_node;
    logic [CHOICE_W-1:0] i_return_choice;
    logic                o_valid;
    logic                o_status;
    logic                o_neighbor_valid;
    logic [NODE_W-1:0]   o_neighbor;
    logic [COUNT_W-1:0]  o_count_after;

    // Mirror of the deque: link tables, both ends and the member count.
    logic [LINK_W-1:0]  link_prev [0:NODES-1];
    logic [LINK_W-1:0]  link_next [0:NODES-1];
    logic [LINK_W-1:0]  front_node;
    logic [LINK_W-1:0]  rear_node;
    logic [COUNT_W-1:0] member_count;

    // Results predicted for accepted items, oldest first.
    t_deque_outcome deque_outcomes [$];
    t_deque_outcome awaited;
    int             mismatch_count;

    // Items left in the current burst of the sender.
    int             burst_left;

    // Handles the stimulus believes to be on the list; only steers the choice of handles.
    bit [NODES-1:0] on_list;

    linked_deque_manager_core u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_kind           (i_kind),
        .i_node           (i_node),
        .i_return_choice  (i_return_choice),
        .o_valid          (o_valid),
        .o_status         (o_status),
        .o_neighbor_valid (o_neighbor_valid),
        .o_neighbor       (o_neighbor),
        .o_count_after    (o_count_after)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Link writes aimed at "none" are dropped, as in the core.
    function automatic void set_prev(input logic [LINK_W-1:0] at, input logic [LINK_W-1:0] value);
        if (at != LINK_NONE) begin
            link_prev[at[ADDR_W-1:0]] = value;
        end
    endfunction

    function automatic void set_next(input logic [LINK_W-1:0] at, input logic [LINK_W-1:0] value);
        if (at != LINK_NONE) begin
            link_next[at[ADDR_W-1:0]] = value;
        end
    endfunction

    // Removes the front member; the caller makes sure the list is not empty.
    function automatic void drop_front();
        logic [LINK_W-1:0] second;
        if (member_count == 1) begin
            front_node = LINK_NONE;
            rear_node  = LINK_NONE;
        end else begin
            second = (front_node == LINK_NONE) ? LINK_NONE : link_next[front_node[ADDR_W-1:0]];
            set_prev(second, LINK_NONE);
            front_node = second;
        end
        member_count--;
    endfunction

    function automatic void drop_rear();
        logic [LINK_W-1:0] second;
        if (member_count == 1) begin
            front_node = LINK_NONE;
            rear_node  = LINK_NONE;
        end else begin
            second = (rear_node == LINK_NONE) ? LINK_NONE : link_prev[rear_node[ADDR_W-1:0]];
            set_next(second, LINK_NONE);
            rear_node = second;
        end
        member_count--;
    endfunction

    // Applies one accepted item to the mirror and returns the result the core must give.
    function automatic t_deque_outcome predict_deque_result(input logic [KIND_W-1:0] kind,
            input logic [NODE_W-1:0] node, input logic [CHOICE_W-1:0] choice);
        t_deque_outcome    res;
        logic [LINK_W-1:0] handle;
        logic [LINK_W-1:0] was_prev;
        logic [LINK_W-1:0] was_next;
        res        = '0;
        res.status = STATUS_DONE;
        handle     = LINK_W'(node);
        case (kind) inside
            KIND_PUSH_FRONT, KIND_PUSH_REAR: begin
                // Both links of a pushed node are always rewritten.
                if (member_count == 0) begin
                    link_prev[node] = LINK_NONE;
                    link_next[node] = LINK_NONE;
                    front_node      = handle;
                    rear_node       = handle;
                end else if (kind == KIND_PUSH_FRONT) begin
                    link_prev[node] = LINK_NONE;
                    link_next[node] = front_node;
                    set_prev(front_node, handle);
                    front_node = handle;
                end else begin
                    link_next[node] = LINK_NONE;
                    link_prev[node] = rear_node;
                    set_next(rear_node, handle);
                    rear_node = handle;
                end
                // A push onto a full list still links the node but the count saturates.
                if (member_count < NODES) begin
                    member_count++;
                end
            end
            KIND_POP_FRONT, KIND_POP_REAR: begin
                if (member_count == 0) begin
                    res.status = STATUS_EMPTY;
                end else if (kind == KIND_POP_FRONT) begin
                    drop_front();
                end else begin
                    drop_rear();
                end
            end
            KIND_UNLINK: begin
                if (member_count == 0) begin
                    res.status = STATUS_EMPTY;
                end else begin
                    was_prev = link_prev[node];
                    was_next = link_next[node];
                    if (was_next == LINK_NONE) begin
                        drop_rear();
                    end else if (was_prev == LINK_NONE) begin
                        drop_front();
                    end else begin
                        set_next(was_prev, was_next);
                        set_prev(was_next, was_prev);
                        member_count--;
                    end
                    if (choice == CHOICE_PREV && was_prev != LINK_NONE) begin
                        res.neighbor_valid = 1'b1;
                        res.neighbor       = was_prev[NODE_W-1:0];
                    end else if (choice == CHOICE_NEXT && was_next != LINK_NONE) begin
                        res.neighbor_valid = 1'b1;
                        res.neighbor       = was_next[NODE_W-1:0];
                    end
                end
            end
            default: begin
                // Reserved kinds leave everything as it is.
            end
        endcase
        res.count_after = member_count;
        return res;
    endfunction

    // Sends one item. The sender works in bursts: when a burst runs out, start drops for a
    // random gap and a new burst length is drawn; some bursts are long to give idle-free
    // stretches. The task returns in the time step of the accepting edge.
    task automatic issue_request(input logic [KIND_W-1:0] kind, input logic [NODE_W-1:0] node,
            input logic [CHOICE_W-1:0] choice);
        if (burst_left == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 50)
                                                     : $urandom_range(1, 8);
        end
        burst_left--;
        start           <= 1'b1;
        i_kind          <= kind;
        i_node          <= node;
        i_return_choice <= choice;
        // The item is taken at the first edge that sees busy low.
        @(posedge i_clk);
        while (busy) begin
            @(posedge i_clk);
        end
        deque_outcomes.push_back(predict_deque_result(kind, node, choice));
    endtask

    // Returns a handle whose on_list bit equals want, starting from a random place.
    function automatic logic [NODE_W-1:0] find_node(input bit want);
        logic [NODE_W-1:0] probe;
        probe = NODE_W'($urandom_range(0, NODES - 1));
        for (int step = 0; step < NODES; step++) begin
            if (on_list[probe] == want) begin
                return probe;
            end
            probe = probe + 1'b1;
        end
        return probe;
    endfunction

    function automatic void compare_field(input string field, input logic [COUNT_W-1:0] want,
            input logic [COUNT_W-1:0] got);
        if (got !== want) begin
            mismatch_count++;
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
        end
    endfunction

    // Every strobed result is matched against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (deque_outcomes.size() == 0) begin
                mismatch_count++;
                $display("%0t: unrequested result: expected none, actual count_after %0d",
                         $time, o_count_after);
            end else begin
                awaited = deque_outcomes.pop_front();
                compare_field("status", COUNT_W'(awaited.status), COUNT_W'(o_status));
                compare_field("neighbor_valid", COUNT_W'(awaited.neighbor_valid),
                              COUNT_W'(o_neighbor_valid));
                compare_field("neighbor", COUNT_W'(awaited.neighbor), COUNT_W'(o_neighbor));
                compare_field("count_after", awaited.count_after, o_count_after);
            end
        end
    end

    // Pops and reserved kinds on a list that has never held anything. No link is read here.
    task automatic test_empty_deque();
        issue_request(KIND_POP_FRONT, 8'h00, CHOICE_NONE);
        issue_request(KIND_POP_REAR, 8'hFF, CHOICE_RESERVED);
        for (int k = KIND_RESERVED_LO; k <= KIND_RESERVED_HI; k++) begin
            issue_request(KIND_W'(k), NODE_W'($urandom), CHOICE_W'($urandom));
        end
    endtask

    // Pushes at both ends with extreme handles, then pops from both ends back to empty.
    task automatic test_end_operations();
        issue_request(KIND_PUSH_FRONT, 8'h00, CHOICE_NONE);
        issue_request(KIND_PUSH_REAR, 8'hFF, CHOICE_PREV);
        issue_request(KIND_PUSH_FRONT, 8'hAA, CHOICE_NEXT);
        issue_request(KIND_PUSH_REAR, 8'h55, CHOICE_RESERVED);
        issue_request(KIND_POP_FRONT, 8'h00, CHOICE_PREV);
        issue_request(KIND_POP_REAR, 8'hFF, CHOICE_NEXT);
        issue_request(KIND_POP_FRONT, 8'h00, CHOICE_NONE);
        issue_request(KIND_POP_REAR, 8'h00, CHOICE_NONE);
    endtask

    // Unlinks from the middle, the tail and the head with the prev, next and reserved return
    // choices, ending with the last member and then an unlink on the emptied list.
    task automatic test_unlink_positions();
        issue_request(KIND_PUSH_REAR, 8'h01, CHOICE_NONE);
        issue_request(KIND_PUSH_REAR, 8'h80, CHOICE_NONE);
        issue_request(KIND_PUSH_REAR, 8'h7F, CHOICE_NONE);
        issue_request(KIND_PUSH_REAR, 8'hFE, CHOICE_NONE);
        issue_request(KIND_PUSH_REAR, 8'h10, CHOICE_NONE);
        issue_request(KIND_UNLINK, 8'h7F, CHOICE_PREV);
        issue_request(KIND_UNLINK, 8'h80, CHOICE_NEXT);
        issue_request(KIND_UNLINK, 8'h10, CHOICE_PREV);
        issue_request(KIND_UNLINK, 8'h01, CHOICE_NEXT);
        issue_request(KIND_RESERVED_HI, 8'hFE, CHOICE_PREV);
        issue_request(KIND_UNLINK, 8'hFE, CHOICE_RESERVED);
        issue_request(KIND_UNLINK, 8'hFE, CHOICE_NEXT);
    endtask

    // Pushes every handle once in random order, which also leaves every link entry written,
    // then pushes two members onto the full list and drains it with pops and unlinks.
    task automatic test_full_deque();
        logic [NODE_W-1:0] order [NODES];
        logic [NODE_W-1:0] swap;
        int                j;
        for (int i = 0; i < NODES; i++) begin
            order[i] = NODE_W'(i);
        end
        for (int i = NODES - 1; i > 0; i--) begin
            j        = $urandom_range(0, i);
            swap     = order[i];
            order[i] = order[j];
            order[j] = swap;
        end
        for (int i = 0; i < NODES; i++) begin
            issue_request(KIND_W'($urandom_range(KIND_PUSH_FRONT, KIND_PUSH_REAR)), order[i],
                          CHOICE_W'($urandom));
        end
        issue_request(KIND_PUSH_FRONT, order[0], CHOICE_W'($urandom));
        issue_request(KIND_PUSH_REAR, order[NODES-1], CHOICE_W'($urandom));
        // Each pop or unlink on a non-empty list removes exactly one member.
        while (member_count != 0) begin
            if ($urandom_range(0, 9) < 7) begin
                issue_request(KIND_W'($urandom_range(KIND_POP_FRONT, KIND_POP_REAR)),
                              NODE_W'($urandom), CHOICE_W'($urandom));
            end else begin
                issue_request(KIND_UNLINK, NODE_W'($urandom), CHOICE_W'($urandom));
            end
        end
    endtask

    // Mostly well-formed traffic that keeps the list short: pushes of outsiders, pops, and
    // unlinks of members. A small share is noise: reserved kinds, pushes of members and
    // unlinks of outsiders. All entries were written by the full-list test.
    task automatic test_random_traffic(input int items);
        int                roll;
        int                push_limit;
        logic [NODE_W-1:0] target;
        on_list = '0;
        for (int i = 0; i < items; i++) begin
            roll       = $urandom_range(0, 99);
            push_limit = (member_count < 20) ? 58 : 35;
            if (roll < 4) begin
                issue_request(KIND_W'($urandom_range(KIND_RESERVED_LO, KIND_RESERVED_HI)),
                              NODE_W'($urandom), CHOICE_W'($urandom));
            end else if (roll < 7) begin
                issue_request(KIND_W'($urandom_range(KIND_PUSH_FRONT, KIND_PUSH_REAR)),
                              find_node(1'b1), CHOICE_W'($urandom));
            end else if (roll < 9) begin
                issue_request(KIND_UNLINK, find_node(1'b0), CHOICE_W'($urandom));
            end else if (roll < push_limit) begin
                target          = find_node(1'b0);
                on_list[target] = 1'b1;
                issue_request(KIND_W'($urandom_range(KIND_PUSH_FRONT, KIND_PUSH_REAR)), target,
                              CHOICE_W'($urandom));
            end else begin
                case ($urandom_range(0, 3))
                    0: begin
                        if (front_node != LINK_NONE) begin
                            on_list[front_node[ADDR_W-1:0]] = 1'b0;
                        end
                        issue_request(KIND_POP_FRONT, NODE_W'($urandom), CHOICE_W'($urandom));
                    end
                    1: begin
                        if (rear_node != LINK_NONE) begin
                            on_list[rear_node[ADDR_W-1:0]] = 1'b0;
                        end
                        issue_request(KIND_POP_REAR, NODE_W'($urandom), CHOICE_W'($urandom));
                    end
                    default: begin
                        target          = find_node(1'b1);
                        on_list[target] = 1'b0;
                        issue_request(KIND_UNLINK, target, CHOICE_W'($urandom));
                    end
                endcase
            end
        end
    endtask

    initial begin
        i_rst_n         = 1'b0;
        start           = 1'b0;
        i_kind          = KIND_PUSH_FRONT;
        i_node          = '0;
        i_return_choice = CHOICE_NONE;
        front_node      = LINK_NONE;
        rear_node       = LINK_NONE;
        member_count    = '0;
        mismatch_count  = 0;
        burst_left      = 0;
        on_list         = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_deque();
        test_end_operations();
        test_unlink_positions();
        test_full_deque();
        test_random_traffic(420);
        start <= 1'b0;

        // Drain the outstanding results, then watch a little longer for stray strobes.
        while (deque_outcomes.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Watchdog for a hung handshake or missing results.
    initial begin
        #2000000;
        $display("FAILURE");
        $finish;
    end

endmodule
